// File: hw/rtl/paf3d_pkg.sv
// Shared widths, types and constants for the fan-triangulation polygon area block.
// Depends on nothing; every other file refers to it by scoped names.
package paf3d_pkg;

	localparam int COORD_W = 16;               // coordinate width, signed fixed point
	localparam int DIFF_W  = COORD_W + 1;      // edge vector component
	localparam int CROSS_W = 2 * DIFF_W + 1;   // cross product component, signed
	localparam int MAG_W   = 2 * COORD_W + 1;  // absolute cross product component
	localparam int MUL_W   = MAG_W + 1;        // shared multiplier operand, signed
	localparam int PROD_W  = 2 * MUL_W;        // shared multiplier product
	localparam int RAD_W   = 2 * MAG_W + 2;    // sum of three squares
	localparam int ROOT_W  = RAD_W / 2;        // floor square root
	localparam int REM_W   = ROOT_W + 3;       // square root partial remainder
	localparam int ITER_W  = $clog2(ROOT_W);   // square root step counter
	localparam int SUM_W   = 41;               // running sum of doubled triangle areas
	localparam int AREA_W  = 40;               // area output, unsigned Q24.16

	localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ROOT_W - 1);
	localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};

	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic [MAG_W-1:0]         mag_t;
	typedef logic [RAD_W-1:0]         rad_t;
	typedef logic [ROOT_W-1:0]        root_t;

	// request into the square root unit
	typedef struct packed {
		logic start;
		rad_t rad;
	} isqrt_req_t;

	// answer from the square root unit
	typedef struct packed {
		logic  done;
		root_t root;
	} isqrt_rsp_t;

endpackage

// File: hw/rtl/polygon_area_fan_3d.sv
// Top level: area of a planar 3D polygon by fan triangulation, one vertex per item.
// Depends on paf3d_pkg and paf3d_isqrt.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   vertex  | in        | in_valid / in_ready  | x, y, z (signed Q8.8), last
//   area    | out       | out_valid / out_ready| area (Q24.16), saturated
//
// A vertex before the third is accepted in S_IDLE and finished in S_OUT.
// From the third vertex on a vertex passes acceptance, the steps on the shared
// multiplier (six cross terms, three squares, a drain, the root start), the
// two-bits-per-cycle square root, then S_ACC to add into the sum and S_OUT to finish.
// in_ready is high only while the sequencer idles. A result waits in the output register;
// a later result holds the sequencer until the earlier one leaves. Reset clears control.
module polygon_area_fan_3d (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [paf3d_pkg::COORD_W-1:0] x,
	input  logic [paf3d_pkg::COORD_W-1:0] y,
	input  logic [paf3d_pkg::COORD_W-1:0] z,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [paf3d_pkg::AREA_W-1:0]  area,
	output logic                          saturated
);

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_SQRT = 3'd2;
	localparam logic [2:0] S_ACC  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	// multiplier schedule: products 0..5 are cross terms, 6..8 are squares
	localparam logic [3:0] STEP_SQ_X  = 4'd6;
	localparam logic [3:0] STEP_SQ_Y  = 4'd7;
	localparam logic [3:0] STEP_SQ_Z  = 4'd8;
	localparam logic [3:0] STEP_START = 4'd10;

	logic [2:0]                     state_q;
	logic [3:0]                     step_q;
	logic [1:0]                     seen_q;
	logic                           last_q;
	logic [paf3d_pkg::SUM_W-1:0]    sum_q;
	logic                           sat_q;
	logic                           out_valid_q;
	logic [paf3d_pkg::AREA_W-1:0]   area_q;
	logic                           saturated_q;

	paf3d_pkg::diff_t               first_x_q, first_y_q, first_z_q;
	paf3d_pkg::diff_t               prev_x_q, prev_y_q, prev_z_q;
	paf3d_pkg::diff_t               ax_q, ay_q, az_q, bx_q, by_q, bz_q;
	logic signed [paf3d_pkg::CROSS_W-1:0] cross_acc_q;
	paf3d_pkg::mag_t                mx_q, my_q, mz_q;
	paf3d_pkg::rad_t                rad_q;
	logic signed [paf3d_pkg::PROD_W-1:0]  prod_s1;

	paf3d_pkg::diff_t               vx, vy, vz;
	logic signed [paf3d_pkg::MUL_W-1:0]   op_a, op_b;
	logic [3:0]                     use_step;
	logic signed [paf3d_pkg::CROSS_W-1:0] cross_k;
	paf3d_pkg::mag_t                cross_mag;
	logic [paf3d_pkg::SUM_W:0]      sum_ext;
	logic                           accept;
	logic                           out_take;
	logic                           out_free;
	logic                           emit;

	paf3d_pkg::isqrt_req_t          sq_req;
	paf3d_pkg::isqrt_rsp_t          sq_rsp;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_take = out_valid_q && out_ready;
	assign out_free = !out_valid_q || out_ready;
	// hand the finished polygon to the output register
	assign emit     = (state_q == S_OUT) && last_q && out_free;

	// widen coordinates from their sign bit
	assign vx = {x[paf3d_pkg::COORD_W-1], x};
	assign vy = {y[paf3d_pkg::COORD_W-1], y};
	assign vz = {z[paf3d_pkg::COORD_W-1], z};

	// shared multiplier operand select
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (step_q)
			4'd0: begin
				op_a = {{(paf3d_pkg::MUL_W-paf3d_pkg::DIFF_W){ay_q[paf3d_pkg::DIFF_W-1]}}, ay_q};
				op_b = {{(paf3d_pkg::MUL_W-paf3d_pkg::DIFF_W){bz_q[paf3d_pkg::DIFF_W-1]}}, bz_q};
			end
			4'd1: begin
				op_a = {{(paf3d_pkg::MUL_W-paf3d_pkg::DIFF_W){az_q[paf3d_pkg::DIFF_W-1]}}, az_q};
				op_b = {{(paf3d_pkg::MUL_W-paf3d_pkg::DIFF_W){by_q[paf3d_pkg::DIFF_W-1]}}, by_q};
			end
			4'd2: begin
				op_a = {{(paf3d_pkg::MUL_W-paf3d_pkg::DIFF_W){az_q[paf3d_pkg::DIFF_W-1]}}, az_q};
				op_b = {{(paf3d_pkg::MUL_W-paf3d_pkg::DIFF_W){bx_q[paf3d_pkg::DIFF_W-1]}}, bx_q};
			end
			4'd3: begin
				op_a = {{(paf3d_pkg::MUL_W-paf3d_pkg::DIFF_W){ax_q[paf3d_pkg::DIFF_W-1]}}, ax_q};
				op_b = {{(paf3d_pkg::MUL_W-paf3d_pkg::DIFF_W){bz_q[paf3d_pkg::DIFF_W-1]}}, bz_q};
			end
			4'd4: begin
				op_a = {{(paf3d_pkg::MUL_W-paf3d_pkg::DIFF_W){ax_q[paf3d_pkg::DIFF_W-1]}}, ax_q};
				op_b = {{(paf3d_pkg::MUL_W-paf3d_pkg::DIFF_W){by_q[paf3d_pkg::DIFF_W-1]}}, by_q};
			end
			4'd5: begin
				op_a = {{(paf3d_pkg::MUL_W-paf3d_pkg::DIFF_W){ay_q[paf3d_pkg::DIFF_W-1]}}, ay_q};
				op_b = {{(paf3d_pkg::MUL_W-paf3d_pkg::DIFF_W){bx_q[paf3d_pkg::DIFF_W-1]}}, bx_q};
			end
			STEP_SQ_X: begin
				op_a = {1'b0, mx_q};
				op_b = {1'b0, mx_q};
			end
			STEP_SQ_Y: begin
				op_a = {1'b0, my_q};
				op_b = {1'b0, my_q};
			end
			STEP_SQ_Z: begin
				op_a = {1'b0, mz_q};
				op_b = {1'b0, mz_q};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// the product registered at step s is used at step s+1
	assign use_step  = step_q - 4'd1;
	assign cross_k   = cross_acc_q - prod_s1[paf3d_pkg::CROSS_W-1:0];
	assign cross_mag = cross_k[paf3d_pkg::CROSS_W-1] ? paf3d_pkg::MAG_W'(-cross_k)
	                                                 : paf3d_pkg::MAG_W'(cross_k);
	assign sum_ext   = {1'b0, sum_q} + (paf3d_pkg::SUM_W+1)'(sq_rsp.root);

	assign sq_req.start = (state_q == S_MUL) && (step_q == STEP_START);
	assign sq_req.rad   = rad_q;

	paf3d_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sq_req),
		.rsp    (sq_rsp)
	);

	// sequencer and accumulated control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			seen_q      <= '0;
			last_q      <= 1'b0;
			sum_q       <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q <= last;
						step_q <= '0;
						if (seen_q != 2'd3) begin
							seen_q <= seen_q + 2'd1;
						end
						// a triangle closes only from the third vertex on
						state_q <= (seen_q >= 2'd2) ? S_MUL : S_OUT;
					end
				end
				S_MUL: begin
					step_q <= step_q + 4'd1;
					if (step_q == STEP_START) begin
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sq_rsp.done) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					// clamp the running sum at its top value
					if (sum_ext[paf3d_pkg::SUM_W]) begin
						sum_q <= paf3d_pkg::SUM_MAX;
						sat_q <= 1'b1;
					end else begin
						sum_q <= sum_ext[paf3d_pkg::SUM_W-1:0];
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						// emit and start a new polygon
						seen_q      <= '0;
						sum_q       <= '0;
						sat_q       <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// vertex and datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			if (seen_q == 2'd0) begin
				first_x_q <= vx;
				first_y_q <= vy;
				first_z_q <= vz;
			end
			prev_x_q <= vx;
			prev_y_q <= vy;
			prev_z_q <= vz;
			ax_q <= prev_x_q - first_x_q;
			ay_q <= prev_y_q - first_y_q;
			az_q <= prev_z_q - first_z_q;
			bx_q <= vx - first_x_q;
			by_q <= vy - first_y_q;
			bz_q <= vz - first_z_q;
		end

		if (state_q == S_MUL) begin
			prod_s1 <= op_a * op_b;
			if (step_q != 4'd0) begin
				unique case (use_step)
					4'd0, 4'd2, 4'd4: cross_acc_q <= prod_s1[paf3d_pkg::CROSS_W-1:0];
					4'd1:             mx_q <= cross_mag;
					4'd3:             my_q <= cross_mag;
					4'd5:             mz_q <= cross_mag;
					STEP_SQ_X:        rad_q <= prod_s1[paf3d_pkg::RAD_W-1:0];
					STEP_SQ_Y, STEP_SQ_Z: rad_q <= rad_q + prod_s1[paf3d_pkg::RAD_W-1:0];
					default:          rad_q <= rad_q;
				endcase
			end
		end

		if (emit) begin
			area_q      <= sum_q[paf3d_pkg::SUM_W-1 -: paf3d_pkg::AREA_W];
			saturated_q <= sat_q;
		end
	end

	assign out_valid = out_valid_q;
	assign area      = area_q;
	assign saturated = saturated_q;

endmodule

// File: hw/rtl/paf3d_isqrt.sv
// Bit-serial floor square root, two radicand bits per cycle.
// Depends on paf3d_pkg.
module paf3d_isqrt (
	input  logic                   clk,
	input  logic                   arst_n,
	input  paf3d_pkg::isqrt_req_t  req,
	output paf3d_pkg::isqrt_rsp_t  rsp
);

	logic                          busy_q;
	logic                          done_q;
	logic [paf3d_pkg::ITER_W-1:0]  iter_q;
	paf3d_pkg::rad_t               rad_q;
	paf3d_pkg::root_t              root_q;
	logic [paf3d_pkg::REM_W-1:0]   rem_q;

	logic [paf3d_pkg::REM_W-1:0]   rem_shift;
	logic [paf3d_pkg::REM_W-1:0]   trial;
	logic                          fits;

	// bring down the next two radicand bits and try a one in the root
	assign rem_shift = {rem_q[paf3d_pkg::REM_W-3:0], rad_q[paf3d_pkg::RAD_W-1 -: 2]};
	assign trial     = {1'b0, root_q, 2'b01};
	assign fits      = (rem_shift >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			// pulse done right after the final step
			done_q <= busy_q && !req.start && (iter_q == paf3d_pkg::ITER_LAST);
			if (req.start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == paf3d_pkg::ITER_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rad_q  <= req.rad;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[paf3d_pkg::RAD_W-3:0], 2'b00};
			if (fits) begin
				rem_q  <= rem_shift - trial;
				root_q <= {root_q[paf3d_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_shift;
				root_q <= {root_q[paf3d_pkg::ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = root_q;

endmodule

// File: hw/rtl/paf3d_checker.sv
// Port-level checks for polygon_area_fan_3d, attached by bind.
// Depends on paf3d_pkg for widths.
module paf3d_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [paf3d_pkg::AREA_W-1:0]  area,
	input logic                          saturated
);

	// a taken vertex always leaves the sequencer busy in the following cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready stayed high after a vertex was taken");

	// a result only appears after the sequencer has been busy
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while the sequencer was idle");

	// a clamped sum reads as the largest area
	a_sat_full_area: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |-> (area == {paf3d_pkg::AREA_W{1'b1}}))
		else $error("saturated result without full-scale area");

	// a waiting result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(area) && $stable(saturated)))
		else $error("result changed while stalled");

endmodule

bind polygon_area_fan_3d paf3d_checker u_paf3d_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.area      (area),
	.saturated (saturated)
);

// File: sim/testbench.sv
// Self-checking testbench for polygon_area_fan_3d: fan-triangulated area of 3D polygons.
// Depends on paf3d_pkg for widths and the sum limit, and on the polygon_area_fan_3d RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VERTEX_TOTAL = 1650;   // rough size of the random part
	localparam int CALM_TAIL    = 120;    // final vertices sent with no idling
	localparam int DRAIN_CYCLES = 100;    // well above one vertex's latency
	localparam int MAX_PRINTS   = 40;     // cap on mismatch lines

	typedef enum int {COORD_FULL, COORD_NEAR, COORD_EDGE} coord_mode_t;

	typedef struct {
		logic [paf3d_pkg::COORD_W-1:0] x;
		logic [paf3d_pkg::COORD_W-1:0] y;
		logic [paf3d_pkg::COORD_W-1:0] z;
		logic                          last;
	} vertex_t;

	typedef struct {
		logic [paf3d_pkg::AREA_W-1:0] area;
		logic                         saturated;
	} area_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [paf3d_pkg::COORD_W-1:0] x = '0;
	logic [paf3d_pkg::COORD_W-1:0] y = '0;
	logic [paf3d_pkg::COORD_W-1:0] z = '0;
	logic last = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [paf3d_pkg::AREA_W-1:0] area;
	logic saturated;

	polygon_area_fan_3d dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.x         (x),
		.y         (y),
		.z         (z),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.area      (area),
		.saturated (saturated)
	);

	always #5 clk = ~clk;

	// Vertices waiting to be sent, and areas the predictor expects, oldest first.
	vertex_t pending_vertices[$];
	area_t   area_expect[$];

	int vertex_count = 0;   // vertices loaded into the stimulus queue
	int area_count   = 0;   // polygons loaded, i.e. areas to come
	int sent         = 0;   // vertices accepted by the block
	int areas_seen   = 0;
	int sat_seen     = 0;
	int fail_count   = 0;

	// Predictor state: fan apex, previous vertex, vertex count and running sum.
	logic signed [paf3d_pkg::COORD_W-1:0] apex_x = '0, apex_y = '0, apex_z = '0;
	logic signed [paf3d_pkg::COORD_W-1:0] prev_x = '0, prev_y = '0, prev_z = '0;
	logic [1:0]                           seen = '0;
	logic [paf3d_pkg::SUM_W-1:0]          mag_sum = '0;
	logic                                 sum_sat = 1'b0;

	task automatic report_mismatch(input string msg);
		if (fail_count < MAX_PRINTS)
			$display("MISMATCH @%0t: %s", $time, msg);
		fail_count++;
	endtask

	// Floor square root of the squared cross product length, one bit per pass.
	function automatic logic [35:0] floor_root(input logic [71:0] n);
		logic [35:0] r;
		logic [35:0] c;
		r = '0;
		for (int b = 35; b >= 0; b--) begin
			c = r | (36'd1 << b);
			if ({36'd0, c} * {36'd0, c} <= n)
				r = c;
		end
		return r;
	endfunction

	// Advance the predictor by one accepted vertex; queue an area on the last one.
	task automatic fan_area_step(input vertex_t v);
		longint vx, vy, vz, ax, ay, az, bx, by, bz, kx, ky, kz;
		logic [35:0] mx, my, mz, root;
		logic [71:0] sq;
		logic [paf3d_pkg::SUM_W:0] trial;
		area_t res;
		vx = longint'($signed(v.x));
		vy = longint'($signed(v.y));
		vz = longint'($signed(v.z));
		if (seen == 2'd0) begin
			apex_x = v.x;
			apex_y = v.y;
			apex_z = v.z;
		end else if (seen >= 2'd2) begin
			ax = longint'(prev_x) - longint'(apex_x);
			ay = longint'(prev_y) - longint'(apex_y);
			az = longint'(prev_z) - longint'(apex_z);
			bx = vx - longint'(apex_x);
			by = vy - longint'(apex_y);
			bz = vz - longint'(apex_z);
			kx = ay * bz - az * by;
			ky = az * bx - ax * bz;
			kz = ax * by - ay * bx;
			mx = 36'(kx < 0 ? -kx : kx);
			my = 36'(ky < 0 ? -ky : ky);
			mz = 36'(kz < 0 ? -kz : kz);
			sq = {36'd0, mx} * {36'd0, mx} + {36'd0, my} * {36'd0, my}
				+ {36'd0, mz} * {36'd0, mz};
			root = floor_root(sq);
			trial = {1'b0, mag_sum} + (paf3d_pkg::SUM_W + 1)'(root);
			// clamp at the top of the sum and latch the flag
			if (trial > {1'b0, paf3d_pkg::SUM_MAX}) begin
				mag_sum = paf3d_pkg::SUM_MAX;
				sum_sat = 1'b1;
			end else begin
				mag_sum = trial[paf3d_pkg::SUM_W-1:0];
			end
		end
		prev_x = v.x;
		prev_y = v.y;
		prev_z = v.z;
		if (seen != 2'd3)
			seen = seen + 2'd1;
		if (v.last) begin
			res.area = mag_sum[paf3d_pkg::AREA_W:1];
			res.saturated = sum_sat;
			area_expect.push_back(res);
			// clear everything for the next polygon
			seen = '0;
			mag_sum = '0;
			sum_sat = 1'b0;
			apex_x = '0; apex_y = '0; apex_z = '0;
			prev_x = '0; prev_y = '0; prev_z = '0;
		end
	endtask

	task automatic push_vertex(input logic [paf3d_pkg::COORD_W-1:0] vx, vy, vz,
			input logic is_last);
		vertex_t v;
		v.x = vx;
		v.y = vy;
		v.z = vz;
		v.last = is_last;
		pending_vertices.push_back(v);
		vertex_count++;
		if (is_last)
			area_count++;
	endtask

	function automatic logic [paf3d_pkg::COORD_W-1:0] pick_coord(input coord_mode_t mode);
		logic [paf3d_pkg::COORD_W-1:0] edges[5];
		edges = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
		case (mode)
			COORD_NEAR: return paf3d_pkg::COORD_W'($urandom_range(0, 2047) - 1024);
			COORD_EDGE: return edges[$urandom_range(0, 4)];
			default:    return paf3d_pkg::COORD_W'($urandom);
		endcase
	endfunction

	task automatic add_polygon(input int n, input coord_mode_t mode);
		for (int i = 0; i < n; i++)
			push_vertex(pick_coord(mode), pick_coord(mode), pick_coord(mode), i == n - 1);
	endtask

	// Points on one line: every fan triangle is degenerate and adds nothing.
	task automatic add_collinear(input int n);
		logic [paf3d_pkg::COORD_W-1:0] bx, by, bz, dx, dy, dz;
		bx = pick_coord(COORD_NEAR);
		by = pick_coord(COORD_NEAR);
		bz = pick_coord(COORD_NEAR);
		dx = paf3d_pkg::COORD_W'($urandom_range(0, 255) - 128);
		dy = paf3d_pkg::COORD_W'($urandom_range(0, 255) - 128);
		dz = paf3d_pkg::COORD_W'($urandom_range(0, 255) - 128);
		for (int i = 0; i < n; i++)
			push_vertex(bx + paf3d_pkg::COORD_W'(i) * dx, by + paf3d_pkg::COORD_W'(i) * dy,
				bz + paf3d_pkg::COORD_W'(i) * dz, i == n - 1);
	endtask

	// Huge triangles swept between two far corners of the coordinate cube, long
	// enough that the running sum clamps before the last vertex.
	task automatic add_saturating(input int n);
		push_vertex(16'h8000, 16'h8000, 16'h8000, 1'b0);
		for (int i = 1; i < n; i++) begin
			if (i % 2 == 1)
				push_vertex(16'h7fff ^ 16'($urandom_range(0, 7)), 16'h7fff, 16'h8000,
					i == n - 1);
			else
				push_vertex(16'h8000, 16'h7fff, 16'h7fff ^ 16'($urandom_range(0, 7)),
					i == n - 1);
		end
	endtask

	// Driver: hold each vertex until taken, advance the predictor on acceptance,
	// and insert bursts of idle cycles except during calm stretches and the tail.
	int      gap_left = 0;
	vertex_t cur_vertex;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready) begin
				fan_area_step(cur_vertex);
				sent++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (!(sent + CALM_TAIL >= vertex_count || (sent / 150) % 4 == 3)
						&& $urandom_range(0, 7) == 0) begin
					gap_left = $urandom_range(1, 19) - 1;
					in_valid <= 1'b0;
				end else if (pending_vertices.size() > 0) begin
					cur_vertex = pending_vertices.pop_front();
					x <= cur_vertex.x;
					y <= cur_vertex.y;
					z <= cur_vertex.z;
					last <= cur_vertex.last;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each accepted area with the oldest prediction, and drop
	// out_ready in random bursts except in calm stretches and near the end.
	int stall_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (area_expect.size() == 0) begin
					report_mismatch($sformatf("unexpected area %0h saturated %0b",
						area, saturated));
				end else begin
					area_t exp_area;
					exp_area = area_expect.pop_front();
					if (area !== exp_area.area)
						report_mismatch($sformatf("area %0d: got %0h, expected %0h",
							areas_seen, area, exp_area.area));
					if (saturated !== exp_area.saturated)
						report_mismatch($sformatf("area %0d: saturated got %0b, expected %0b",
							areas_seen, saturated, exp_area.saturated));
					if (exp_area.saturated)
						sat_seen++;
				end
				areas_seen++;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!(areas_seen + 20 >= area_count || (areas_seen / 25) % 3 == 2)
					&& $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 19) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int n;
		int pick;
		// directed: lone vertex and a pair give zero area
		push_vertex(16'h7fff, 16'h8000, 16'hffff, 1'b1);
		push_vertex(16'h8000, 16'h7fff, 16'h0001, 1'b0);
		push_vertex(16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
		// widest triangle the coordinates allow
		push_vertex(16'h8000, 16'h8000, 16'h8000, 1'b0);
		push_vertex(16'h7fff, 16'h7fff, 16'h8000, 1'b0);
		push_vertex(16'h8000, 16'h7fff, 16'h7fff, 1'b1);
		// collinear triangle adds zero
		push_vertex(16'h0000, 16'h0000, 16'h0000, 1'b0);
		push_vertex(16'h0100, 16'h0100, 16'h0100, 1'b0);
		push_vertex(16'h0200, 16'h0200, 16'h0200, 1'b1);
		// unit square in the xy plane: area exactly 1.0
		push_vertex(16'h0000, 16'h0000, 16'h0000, 1'b0);
		push_vertex(16'h0100, 16'h0000, 16'h0000, 1'b0);
		push_vertex(16'h0100, 16'h0100, 16'h0000, 1'b0);
		push_vertex(16'h0000, 16'h0100, 16'h0000, 1'b1);
		// the same point four times
		for (int i = 0; i < 4; i++)
			push_vertex(16'hffff, 16'h8000, 16'h7fff, i == 3);
		// pentagon in the yz plane at negative coordinates
		push_vertex(16'hfc00, 16'hfe00, 16'hfe00, 1'b0);
		push_vertex(16'hfc00, 16'hff00, 16'hfe00, 1'b0);
		push_vertex(16'hfc00, 16'hff80, 16'hff00, 1'b0);
		push_vertex(16'hfc00, 16'hff00, 16'hffc0, 1'b0);
		push_vertex(16'hfc00, 16'hfe00, 16'hff00, 1'b1);

		// random: two clamping polygons, then mostly ordinary polygons
		add_saturating($urandom_range(330, 360));
		add_saturating($urandom_range(330, 360));
		while (vertex_count < VERTEX_TOTAL) begin
			pick = $urandom_range(0, 99);
			if (pick < 8)
				n = $urandom_range(1, 2);
			else if (pick < 90)
				n = $urandom_range(3, 8);
			else
				n = $urandom_range(9, 20);
			pick = $urandom_range(0, 9);
			if (pick < 5)
				add_polygon(n, COORD_FULL);
			else if (pick < 8)
				add_polygon(n, COORD_NEAR);
			else if (pick < 9)
				add_polygon(n, COORD_EDGE);
			else
				add_collinear(n);
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for every vertex to go in and every area to come out
		while (sent < vertex_count)
			@(posedge clk);
		while (area_expect.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d vertices in %0d polygons; checked %0d areas, %0d of them clamped.",
			sent, area_count, areas_seen, sat_seen);
		if (fail_count == 0)
			$display("polygon_area_fan_3d verification clean");
		else
			$display("polygon_area_fan_3d verification failed");
		$finish;
	end

	// Hard stop well past the slowest correct run.
	initial begin
		#10_000_000;
		$display("Timeout: %0d of %0d vertices sent, %0d areas outstanding.",
			sent, vertex_count, area_expect.size());
		$display("polygon_area_fan_3d verification failed");
		$finish;
	end

endmodule
